// ===== rtl/key_turbo_repeater_assert.svh =====
// Assertion macros for the checker in ktr_checker.sv.
// Every property is clocked on clk and switched off while rst_n is low.
`ifndef KEY_TURBO_REPEATER_ASSERT_SVH
`define KEY_TURBO_REPEATER_ASSERT_SVH

// Check that a condition holds at every clock edge.
`define KTR_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("key turbo repeater check failed");

// Check that a consequent holds in the cycle after its antecedent.
`define KTR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key turbo repeater check failed");

`endif

// ===== rtl/ktr_pkg.sv =====
package ktr_pkg;

    // Request kinds; code three carries no meaning and is dropped
    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    // Sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DOWN = 2'd2,
        PH_UP   = 2'd3
    } phase_t;

    // Emitted key actions
    localparam logic ACT_PRESS   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_HOLD_DELAY = 2'd0;
    localparam logic [1:0] REG_PRESS_TIME = 2'd1;
    localparam logic [1:0] REG_PAUSE_TIME = 2'd2;

    // Configuration reset values
    localparam logic [15:0] HOLD_DELAY_RESET = 16'd200;
    localparam logic [15:0] PRESS_TIME_RESET = 16'd10;
    localparam logic [15:0] PAUSE_TIME_RESET = 16'd10;

    // Input request
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key_code;
    } cmd_t;

    // Emitted key event
    typedef struct packed {
        logic        action;
        logic [31:0] out_key;
    } evt_t;

    // Timing configuration as seen by the sequencer
    typedef struct packed {
        logic [15:0] hold_delay_ms;
        logic [15:0] press_time_ms;
        logic [15:0] pause_time_ms;
    } ktr_cfg_t;

    // Sequencer result for one request
    typedef struct packed {
        logic valid;
        evt_t evt;
    } ktr_res_t;

endpackage

// ===== rtl/ktr_cfg_regs.sv =====
module ktr_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output ktr_pkg::ktr_cfg_t cfg
);
    import ktr_pkg::*;

    logic [15:0] hold_delay_reg;
    logic [15:0] press_time_reg;
    logic [15:0] pause_time_reg;

    // Take a register write; index three is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_delay_reg <= HOLD_DELAY_RESET;
            press_time_reg <= PRESS_TIME_RESET;
            pause_time_reg <= PAUSE_TIME_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HOLD_DELAY: hold_delay_reg <= cfg_data;
                REG_PRESS_TIME: press_time_reg <= cfg_data;
                REG_PAUSE_TIME: pause_time_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg.hold_delay_ms = hold_delay_reg;
    assign cfg.press_time_ms = press_time_reg;
    assign cfg.pause_time_ms = pause_time_reg;

endmodule

// ===== rtl/ktr_seq.sv =====
module ktr_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  ktr_pkg::cmd_t     cmd,
    input  ktr_pkg::ktr_cfg_t cfg,
    output ktr_pkg::ktr_res_t res
);
    import ktr_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] remain_reg;
    logic [15:0] remain_next;
    logic [31:0] stored_key_reg;
    logic [31:0] stored_key_next;

    // Hold phase, countdown and replayed key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            remain_reg     <= '0;
            stored_key_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            remain_reg     <= remain_next;
            stored_key_reg <= stored_key_next;
        end
    end

    // Work out the next state and the emitted event for one request
    always_comb
    begin
        phase_next      = phase_reg;
        remain_next     = remain_reg;
        stored_key_next = stored_key_reg;
        res.valid       = 1'b0;
        res.evt.action  = ACT_PRESS;
        res.evt.out_key = stored_key_reg;
        case (cmd.kind)
            KIND_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (remain_reg > 16'd1)
                    begin
                        remain_next = remain_reg - 16'd1;
                    end
                    else if (phase_reg == PH_DOWN)
                    begin
                        // Press time over: release and start the pause
                        phase_next     = PH_UP;
                        remain_next    = cfg.pause_time_ms;
                        res.valid      = 1'b1;
                        res.evt.action = ACT_RELEASE;
                    end
                    else
                    begin
                        // Hold delay or pause over: press again
                        phase_next     = PH_DOWN;
                        remain_next    = cfg.press_time_ms;
                        res.valid      = 1'b1;
                        res.evt.action = ACT_PRESS;
                    end
                end
            end
            KIND_PRESS:
            begin
                stored_key_next = cmd.key_code;
                phase_next      = PH_WAIT;
                remain_next     = cfg.hold_delay_ms;
                res.valid       = 1'b1;
                res.evt.action  = ACT_PRESS;
                res.evt.out_key = cmd.key_code;
            end
            KIND_RELEASE:
            begin
                phase_next      = PH_IDLE;
                remain_next     = '0;
                res.valid       = 1'b1;
                res.evt.action  = ACT_RELEASE;
                res.evt.out_key = cmd.key_code;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/key_turbo_repeater.sv =====
// Keyboard turbo repeater: a press request is echoed as a press event and,
// if no release follows within hold_delay_ms ticks, the stored key is
// replayed as press/release pairs (press_time_ms down, pause_time_ms up)
// until the next press or release request. Requests are taken one per clock
// cycle unless cmd_stall is high; each passes an input register, one state
// update in the sequencer and a result register before its event appears
// on evt, and evt_stall can hold it back at either register.
// Configuration writes are always ready and should be made while the block
// is quiet; a running countdown keeps its count and new values apply at
// the next reload.
module key_turbo_repeater (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  ktr_pkg::cmd_t  cmd,
    output logic           evt_valid,
    input  logic           evt_stall,
    output ktr_pkg::evt_t  evt,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data
);
    import ktr_pkg::*;

    logic     cmd_valid_reg;
    cmd_t     cmd_reg;
    logic     evt_valid_reg;
    evt_t     evt_reg;
    logic     out_free;
    logic     fire;
    ktr_cfg_t cfg;
    ktr_res_t res;

    assign cfg_ready = 1'b1;

    // Result slot frees when empty or when its event is taken
    assign out_free  = !evt_valid_reg || !evt_stall;
    assign fire      = cmd_valid_reg && out_free;
    assign cmd_stall = cmd_valid_reg && !out_free;

    ktr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ktr_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cmd   (cmd_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Capture a request whenever the input register is not stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            cmd_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd_stall && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
    end

    // Advance the result register when its slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            evt_valid_reg <= fire && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
        begin
            evt_reg <= res.evt;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

// ===== rtl/ktr_checker.sv =====
`include "key_turbo_repeater_assert.svh"

module ktr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input ktr_pkg::cmd_t cmd,
    input logic          evt_valid,
    input logic          evt_stall,
    input ktr_pkg::evt_t evt
);
    import ktr_pkg::*;

    logic press_go;
    logic release_go;

    // Press or release request accepted by the input register
    assign press_go   = cmd_valid && !cmd_stall && (cmd.kind == KIND_PRESS);
    assign release_go = cmd_valid && !cmd_stall && (cmd.kind == KIND_RELEASE);

    // A held event does not change
    `KTR_ASSERT_NEXT(a_evt_hold, evt_valid && evt_stall, evt_valid && $stable(evt))

    // Input backs up only behind a stalled event
    `KTR_ASSERT(a_stall_cause, !cmd_stall || (evt_valid && evt_stall))

    // A press request is echoed as a press of its own key
    `KTR_ASSERT_NEXT(a_press_echo, press_go ##1 !evt_stall,
        evt_valid && (evt.action == ACT_PRESS) && (evt.out_key == $past(cmd.key_code, 2)))

    // A release request yields a release of its own key when evt_stall lets it through
    `KTR_ASSERT_NEXT(a_release_echo, release_go ##1 !evt_stall,
        evt_valid && (evt.action == ACT_RELEASE) && (evt.out_key == $past(cmd.key_code, 2)))

endmodule

bind key_turbo_repeater ktr_checker u_ktr_checker (.*);
